@@ hw/rtl/sbf_pkg.sv @@
package sbf_pkg;

    localparam int MAX_LAYERS      = 4;
    localparam int SLOTS_PER_LAYER = 2097152;
    localparam int MAX_HASHES      = 31;

    localparam int LAYER_W     = $clog2(MAX_LAYERS);
    localparam int SLOT_W      = $clog2(SLOTS_PER_LAYER);
    localparam int ADDR_W      = LAYER_W + SLOT_W;
    localparam int STORE_DEPTH = MAX_LAYERS * SLOTS_PER_LAYER;
    localparam int CNT_W       = 33;
    localparam int OPEN_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0]       CTR_MAX = 8'd255;
    localparam logic [23:0]      FIRST_CAP_RESET = 24'd10000;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CHECK  = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        CFG_BASE_CAPACITY,
        CFG_GROWTH_MULTIPLIER,
        CFG_SLOTS_LAYER0,
        CFG_SLOTS_LAYER1,
        CFG_SLOTS_LAYER2,
        CFG_SLOTS_LAYER3,
        CFG_HASH_COUNTS
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_CHECK,
        OP_REMOVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] key;
    } item_t;

    typedef struct packed {
        logic [23:0]      first_cap;
        logic [3:0]       growth_multiplier;
        logic [3:0][21:0] slots_layer;
        logic [19:0]      hash_counts_packed;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_CHK,
        ST_LAYER,
        ST_MOD_HI,
        ST_MOD_LO,
        ST_RD,
        ST_DATA,
        ST_FINISH
    } back_state_t;

    function automatic logic [SLOT_W:0] slots_of(cfg_t cfg, logic [LAYER_W-1:0] layer);
        logic [21:0] s;
        s = cfg.slots_layer[layer];
        if (s == 22'd0) s = 22'd1;
        if (s > 22'(SLOTS_PER_LAYER)) s = 22'(SLOTS_PER_LAYER);
        return (SLOT_W+1)'(s);
    endfunction

    function automatic logic [4:0] hashes_of(cfg_t cfg, logic [LAYER_W-1:0] layer);
        logic [4:0] k;
        k = cfg.hash_counts_packed[5*layer +: 5];
        if (k > 5'(MAX_HASHES)) k = 5'(MAX_HASHES);
        return k;
    endfunction

endpackage

@@ hw/rtl/sbf_ram.sv @@
module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sbf_mod.sv @@
module sbf_mod (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [31:0]               dividend,
    input  logic [sbf_pkg::SLOT_W:0]  divisor,
    output logic                      done,
    output logic [sbf_pkg::SLOT_W:0]  rem
);
    import sbf_pkg::*;

    logic [SLOT_W+1:0] rem_reg, rem_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SLOT_W+1:0] trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SLOT_W:0], dvd_reg[31]};
        if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
            end else begin
                rem_next = trial;
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[SLOT_W:0];

endmodule

@@ hw/rtl/sbf_front.sv @@
module sbf_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_func,
    input  logic [63:0]    s_key_hash,
    output logic           q_valid,
    output sbf_pkg::item_t q_item,
    input  logic           q_pop
);
    import sbf_pkg::*;

    item_t      queue_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      in_item;

    always_comb begin
        unique case (s_func)
            FUNC_ADD:    in_item.op = OP_ADD;
            FUNC_CHECK:  in_item.op = OP_CHECK;
            FUNC_REMOVE: in_item.op = OP_REMOVE;
            default:     in_item.op = OP_NOP;
        endcase
        in_item.key = s_key_hash;
    end

    assign s_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/sbf_back.sv @@
module sbf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sbf_pkg::cfg_t  cfg,
    input  logic           base_wr,
    input  logic [23:0]    base_value,
    input  logic           q_valid,
    input  sbf_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_found,
    output logic [2:0]     m_layers_in_use,
    output logic           m_layers_exhausted
);
    import sbf_pkg::*;

    back_state_t       state_reg, state_next;
    op_t               op_reg, op_next;
    logic [63:0]       key_reg, key_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [OPEN_W-1:0] open_reg, open_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  cnt_reg [MAX_LAYERS];
    logic              cnt_we;
    logic [LAYER_W-1:0] cnt_widx;
    logic [CNT_W-1:0]  cnt_wval;
    logic [SLOT_W-1:0] hm_reg, hm_next;
    logic [SLOT_W-1:0] dm_reg, dm_next;
    logic [SLOT_W-1:0] r_reg, r_next;
    logic [4:0]        i_reg, i_next;
    logic              pass_reg, pass_next;
    logic              found_reg, found_next;
    logic              exh_reg, exh_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic              of_reg, of_next;
    logic [OPEN_W-1:0] ol_reg, ol_next;
    logic              oe_reg, oe_next;

    logic [SLOT_W:0]   slots;
    logic [4:0]        k;
    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W+3:0]  cap_prod;
    logic [3:0]        growth;
    logic [SLOT_W:0]   r_sum;
    logic [SLOT_W-1:0] r_adv;
    logic              mod_start, mod_done;
    logic [31:0]       mod_dvd;
    logic [SLOT_W:0]   mod_rem;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              last;

    assign slots   = slots_of(cfg, layer_reg);
    assign k       = hashes_of(cfg, layer_reg);
    assign cnt_cur = cnt_reg[layer_reg];
    assign growth  = (cfg.growth_multiplier == 4'd0) ? 4'd1 : cfg.growth_multiplier;
    assign cap_prod = cap_reg * growth;
    assign r_sum   = {1'b0, r_reg} + {1'b0, dm_reg};
    assign r_adv   = (r_sum >= slots) ? SLOT_W'(r_sum - slots) : SLOT_W'(r_sum);
    assign last    = (i_reg == k - 5'd1);
    assign mod_dvd = (state_reg == ST_LAYER) ? key_reg[63:32] : key_reg[31:0];

    sbf_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (slots),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    sbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        layer_next = layer_reg;
        open_next  = open_reg;
        cap_next   = cap_reg;
        hm_next    = hm_reg;
        dm_next    = dm_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        pass_next  = pass_reg;
        found_next = found_reg;
        exh_next   = exh_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg && !m_ready;
        of_next    = of_reg;
        ol_next    = ol_reg;
        oe_next    = oe_reg;
        cnt_we     = 1'b0;
        cnt_widx   = layer_reg;
        cnt_wval   = cnt_cur;
        mod_start  = 1'b0;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = {layer_reg, r_reg};
        ram_wdata  = '0;

        if (base_wr && open_reg == OPEN_W'(1)) begin
            cap_next = CNT_W'(base_value);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid && !ov_reg) begin
                    q_pop      = 1'b1;
                    op_next    = q_item.op;
                    key_next   = q_item.key;
                    layer_next = LAYER_W'(open_reg - OPEN_W'(1));
                    found_next = 1'b0;
                    exh_next   = 1'b0;
                    pass_next  = 1'b0;
                    unique case (q_item.op) inside
                        OP_ADD:              state_next = ST_ADD_CHK;
                        OP_CHECK, OP_REMOVE: state_next = ST_LAYER;
                        default:             state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ADD_CHK: begin
                state_next = ST_LAYER;
                if (cnt_cur >= cap_reg) begin
                    if (open_reg < OPEN_W'(MAX_LAYERS)) begin
                        cap_next   = (cap_prod > (CNT_W+4)'(CNT_MAX)) ? CNT_MAX
                                                                      : CNT_W'(cap_prod);
                        layer_next = LAYER_W'(open_reg);
                        open_next  = open_reg + OPEN_W'(1);
                        cnt_we     = 1'b1;
                        cnt_widx   = LAYER_W'(open_reg);
                        cnt_wval   = '0;
                    end else begin
                        exh_next = 1'b1;
                    end
                end
            end
            ST_LAYER: begin
                if (k == 5'd0) begin
                    // empty hash set: layer matches, no counter store entries touched
                    state_next = ST_FINISH;
                    if (op_reg == OP_ADD) begin
                        cnt_we   = 1'b1;
                        cnt_wval = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
                    end else begin
                        found_next = 1'b1;
                        if (op_reg == OP_REMOVE) begin
                            cnt_we   = 1'b1;
                            cnt_wval = (cnt_cur == '0) ? cnt_cur : cnt_cur - CNT_W'(1);
                        end
                    end
                end else begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD_HI;
                end
            end
            ST_MOD_HI: begin
                if (mod_done) begin
                    hm_next    = SLOT_W'(mod_rem);
                    mod_start  = 1'b1;
                    state_next = ST_MOD_LO;
                end
            end
            ST_MOD_LO: begin
                if (mod_done) begin
                    dm_next    = SLOT_W'(mod_rem);
                    r_next     = hm_reg;
                    i_next     = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                r_next     = r_adv;
                i_next     = i_reg + 5'd1;
                state_next = ST_RD;
                if (op_reg == OP_ADD) begin
                    ram_we    = 1'b1;
                    ram_wdata = (ram_rdata == CTR_MAX) ? ram_rdata : ram_rdata + 8'd1;
                    if (last) begin
                        cnt_we     = 1'b1;
                        cnt_wval   = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
                        state_next = ST_FINISH;
                    end
                end else if (!pass_reg) begin
                    if (ram_rdata == 8'd0) begin
                        if (layer_reg == '0) begin
                            state_next = ST_FINISH;
                        end else begin
                            layer_next = layer_reg - LAYER_W'(1);
                            state_next = ST_LAYER;
                        end
                    end else if (last) begin
                        found_next = 1'b1;
                        if (op_reg == OP_REMOVE) begin
                            pass_next = 1'b1;
                            r_next    = hm_reg;
                            i_next    = '0;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = (ram_rdata == 8'd0) ? ram_rdata : ram_rdata - 8'd1;
                    if (last) begin
                        cnt_we     = 1'b1;
                        cnt_wval   = (cnt_cur == '0) ? cnt_cur : cnt_cur - CNT_W'(1);
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                ov_next    = 1'b1;
                of_next    = found_reg;
                ol_next    = open_reg;
                oe_next    = exh_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            open_reg  <= OPEN_W'(1);
            cap_reg   <= CNT_W'(FIRST_CAP_RESET);
            ov_reg    <= 1'b0;
            for (int n = 0; n < MAX_LAYERS; n++) begin
                cnt_reg[n] <= '0;
            end
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            open_reg  <= open_next;
            cap_reg   <= cap_next;
            ov_reg    <= ov_next;
            if (cnt_we) begin
                cnt_reg[cnt_widx] <= cnt_wval;
            end
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        layer_reg <= layer_next;
        hm_reg    <= hm_next;
        dm_reg    <= dm_next;
        r_reg     <= r_next;
        i_reg     <= i_next;
        pass_reg  <= pass_next;
        found_reg <= found_next;
        exh_reg   <= exh_next;
        of_reg    <= of_next;
        ol_reg    <= ol_next;
        oe_reg    <= oe_next;
    end

    assign m_valid            = ov_reg;
    assign m_found            = of_reg;
    assign m_layers_in_use    = ol_reg;
    assign m_layers_exhausted = oe_reg;

endmodule

@@ hw/rtl/scalable_counting_bloom_filter.sv @@
// Channel  | Handshake            | Payload
// s_       | s_valid / s_ready    | s_func[1:0], s_key_hash[63:0]
// m_       | m_valid / m_ready    | m_found, m_layers_in_use[2:0], m_layers_exhausted
// cfg_     | cfg_valid / cfg_ready| cfg_index[2:0], cfg_data[23:0]
//
// Pop to m_valid: add may first open a layer; check/remove scan layers. Per layer: setup,
// two modulo passes in the shared divider and a read per counter; only setup if k is zero.
// Remove adds a second pass (read, then write on one port) over the matching layer.
// The next item is popped only once the result has been accepted: one item at a time.
// After reset a clearing pass zeroes the counter store; meanwhile only the queue fills.
// A two-entry queue decouples input acceptance; results wait in an output register.
module scalable_counting_bloom_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_key_hash,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [2:0]  m_layers_in_use,
    output logic        m_layers_exhausted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sbf_pkg::*;

    cfg_t  cfg_reg;
    logic  cfg_wr;
    logic  base_wr;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign base_wr   = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_BASE_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_cap          <= FIRST_CAP_RESET;
            cfg_reg.growth_multiplier  <= 4'd2;
            cfg_reg.slots_layer[0]     <= 22'd143776;
            cfg_reg.slots_layer[1]     <= 22'd291938;
            cfg_reg.slots_layer[2]     <= 22'd592647;
            cfg_reg.slots_layer[3]     <= 22'd1202838;
            cfg_reg.hash_counts_packed <= 20'd372074;
        end else if (cfg_wr) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE_CAPACITY:     cfg_reg.first_cap          <= cfg_data;
                CFG_GROWTH_MULTIPLIER: cfg_reg.growth_multiplier  <= cfg_data[3:0];
                CFG_SLOTS_LAYER0:      cfg_reg.slots_layer[0]     <= cfg_data[21:0];
                CFG_SLOTS_LAYER1:      cfg_reg.slots_layer[1]     <= cfg_data[21:0];
                CFG_SLOTS_LAYER2:      cfg_reg.slots_layer[2]     <= cfg_data[21:0];
                CFG_SLOTS_LAYER3:      cfg_reg.slots_layer[3]     <= cfg_data[21:0];
                CFG_HASH_COUNTS:       cfg_reg.hash_counts_packed <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    sbf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_key_hash (s_key_hash),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    sbf_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .base_wr            (base_wr),
        .base_value         (cfg_data),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found            (m_found),
        .m_layers_in_use    (m_layers_in_use),
        .m_layers_exhausted (m_layers_exhausted)
    );

endmodule

@@ hw/rtl/sbf_checker.sv @@
module sbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [2:0]  m_layers_in_use,
    input logic        m_layers_exhausted
);
    import sbf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found)
            && $stable(m_layers_in_use) && $stable(m_layers_exhausted))
        else $error("result changed while stalled");

    a_layers_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_layers_in_use >= 3'd1 && m_layers_in_use <= 3'(MAX_LAYERS))
        else $error("layers_in_use out of range");

    a_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_layers_exhausted))
        else $error("found and exhausted together");

    a_exh_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_layers_exhausted |-> m_layers_in_use == 3'(MAX_LAYERS))
        else $error("exhausted before all layers open");

endmodule

bind scalable_counting_bloom_filter sbf_checker u_sbf_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

import sbf_pkg::*;

class bloom_scoreboard;
    typedef struct {
        logic       found;
        logic [2:0] layers;
        logic       exhausted;
    } outcome_t;

    bit [7:0]         counters[int unsigned];
    logic [CNT_W-1:0] item_count[MAX_LAYERS];
    logic [CNT_W-1:0] top_capacity;
    int unsigned      open_layers;
    logic [23:0]      base_cap;
    logic [3:0]       growth;
    logic [21:0]      slots[4];
    logic [19:0]      hash_cfg;
    outcome_t         expected_q[$];
    int               errors;
    int               results_seen;
    int               hits_seen;
    int               exhausted_seen;

    function new();
        base_cap     = 24'd10000;
        growth       = 4'd2;
        slots[0]     = 22'd143776;
        slots[1]     = 22'd291938;
        slots[2]     = 22'd592647;
        slots[3]     = 22'd1202838;
        hash_cfg     = 20'd372074;
        top_capacity = CNT_W'(base_cap);
        open_layers  = 1;
        foreach (item_count[l]) item_count[l] = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [23:0] data);
        case (idx)
            CFG_BASE_CAPACITY: begin
                base_cap = data;
                if (open_layers == 1) top_capacity = CNT_W'(data);
            end
            CFG_GROWTH_MULTIPLIER: growth = data[3:0];
            CFG_SLOTS_LAYER0:      slots[0] = data[21:0];
            CFG_SLOTS_LAYER1:      slots[1] = data[21:0];
            CFG_SLOTS_LAYER2:      slots[2] = data[21:0];
            CFG_SLOTS_LAYER3:      slots[3] = data[21:0];
            CFG_HASH_COUNTS:       hash_cfg = data[19:0];
            default: ;
        endcase
    endfunction

    function longint unsigned layer_slots(int l);
        longint unsigned s;
        s = slots[l];
        if (s == 0) s = 1;
        if (s > SLOTS_PER_LAYER) s = SLOTS_PER_LAYER;
        return s;
    endfunction

    function int unsigned layer_hashes(int l);
        return (hash_cfg >> (5 * l)) & 20'd31;
    endfunction

    function int unsigned slot_addr(int l, logic [63:0] key, int unsigned i);
        longint unsigned hi, lo;
        hi = key[63:32];
        lo = key[31:0];
        return l * SLOTS_PER_LAYER + int'((hi + i * lo) % layer_slots(l));
    endfunction

    function bit [7:0] ctr(int unsigned a);
        return counters.exists(a) ? counters[a] : 8'd0;
    endfunction

    function bit layer_hit(int l, logic [63:0] key);
        for (int unsigned i = 0; i < layer_hashes(l); i++)
            if (ctr(slot_addr(l, key, i)) == 0) return 0;
        return 1;
    endfunction

    // predict one accepted transaction and queue its outcome
    function void note_item(logic [1:0] func, logic [63:0] key);
        outcome_t        o;
        int              top;
        int unsigned     a;
        longint unsigned cap;
        o.found     = 0;
        o.exhausted = 0;
        top = open_layers - 1;
        if (func == FUNC_ADD) begin
            if (item_count[top] >= top_capacity) begin
                if (open_layers < MAX_LAYERS) begin
                    cap = longint'(top_capacity) * ((growth == 0) ? 1 : growth);
                    top_capacity = (cap > CNT_MAX) ? CNT_MAX : CNT_W'(cap);
                    top = open_layers;
                    open_layers++;
                    item_count[top] = '0;
                end else begin
                    o.exhausted = 1;
                end
            end
            for (int unsigned i = 0; i < layer_hashes(top); i++) begin
                a = slot_addr(top, key, i);
                if (ctr(a) < CTR_MAX) counters[a] = ctr(a) + 8'd1;
            end
            if (item_count[top] < CNT_MAX) item_count[top]++;
        end else if (func == FUNC_CHECK || func == FUNC_REMOVE) begin
            for (int l = open_layers - 1; l >= 0; l--) begin
                if (layer_hit(l, key)) begin
                    o.found = 1;
                    if (func == FUNC_REMOVE) begin
                        for (int unsigned i = 0; i < layer_hashes(l); i++) begin
                            a = slot_addr(l, key, i);
                            if (ctr(a) > 0) counters[a] = ctr(a) - 8'd1;
                        end
                        if (item_count[l] > 0) item_count[l]--;
                    end
                    break;
                end
            end
        end
        o.layers = 3'(open_layers);
        expected_q.insert(expected_q.size(), o);
    endfunction

    function void check_result(logic found, logic [2:0] layers, logic exhausted);
        outcome_t o;
        if (expected_q.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
            return;
        end
        o = expected_q.pop_front();
        results_seen++;
        hits_seen += found;
        exhausted_seen += exhausted;
        if (found !== o.found) begin
            $error("found: expected %0d actual %0d", o.found, found);
            errors++;
        end
        if (layers !== o.layers) begin
            $error("layers_in_use: expected %0d actual %0d", o.layers, layers);
            errors++;
        end
        if (exhausted !== o.exhausted) begin
            $error("layers_exhausted: expected %0d actual %0d", o.exhausted, exhausted);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam longint CYCLE_LIMIT = 64'd8388608 + 64'd6000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [63:0] s_key_hash = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_found;
    logic [2:0]  m_layers_in_use;
    logic        m_layers_exhausted;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    bloom_scoreboard sb = new();
    longint          cycles = 0;
    bit              no_idle = 0;
    logic [63:0]     key_pool[48];
    int              items_sent = 0;

    scalable_counting_bloom_filter dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_found, m_layers_in_use, m_layers_exhausted);

    task automatic send_item(logic [1:0] func, logic [63:0] key);
        while (!no_idle && $urandom_range(99) < 33) @(negedge aclk);
        s_valid    = 1;
        s_func     = func;
        s_key_hash = key;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(func, key);
        items_sent++;
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] data);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic setup(logic [23:0] base, logic [3:0] g, logic [21:0] s0, logic [21:0] s1,
                         logic [21:0] s2, logic [21:0] s3, logic [19:0] hc);
        drain();
        write_reg(CFG_BASE_CAPACITY, base);
        write_reg(CFG_GROWTH_MULTIPLIER, {20'd0, g});
        write_reg(CFG_SLOTS_LAYER0, {2'd0, s0});
        write_reg(CFG_SLOTS_LAYER1, {2'd0, s1});
        write_reg(CFG_SLOTS_LAYER2, {2'd0, s2});
        write_reg(CFG_SLOTS_LAYER3, {2'd0, s3});
        write_reg(CFG_HASH_COUNTS, {4'd0, hc});
    endtask

    task automatic random_items(int n);
        int          r;
        logic [1:0]  func;
        logic [63:0] key;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            func = (r < 40) ? FUNC_ADD : (r < 75) ? FUNC_CHECK :
                   (r < 95) ? FUNC_REMOVE : OP_NOP;
            if ($urandom_range(99) < 70)
                key = key_pool[$urandom_range(47)];
            else
                key = {$urandom, $urandom};
            send_item(func, key);
        end
    endtask

    initial begin
        logic [63:0] dk[4];
        dk = '{64'd0, '1, {32'hFFFF_FFFF, 32'd0}, {32'd0, 32'hFFFF_FFFF}};
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (11) @(negedge aclk);
        aresetn = 1;

        // defaults after reset: every op on extreme keys, hit/miss/remove pairs
        foreach (dk[i]) begin
            send_item(FUNC_CHECK, dk[i]);
            send_item(FUNC_ADD, dk[i]);
            send_item(FUNC_CHECK, dk[i]);
            send_item(OP_NOP, dk[i]);
        end
        send_item(FUNC_REMOVE, dk[0]);
        send_item(FUNC_REMOVE, dk[0]);
        send_item(FUNC_CHECK, dk[0]);
        send_item(FUNC_REMOVE, key_pool[0]);

        // huge capacity reloads while one layer open; zero and oversized slot counts
        setup(24'hFF_FFFF, 4'd8, 22'd0, 22'd1, 22'd2097152, 22'h3F_FFFF,
              {5'd5, 5'd0, 5'd1, 5'd31});
        random_items(250);
        // small capacity reload, growth zero: layers open up, then run out
        setup(24'd2, 4'd0, 22'd64, 22'd100, 22'd37, 22'd2097151,
              {5'd31, 5'd2, 5'd3, 5'd4});
        no_idle = 1;
        random_items(150);
        no_idle = 0;
        random_items(150);
        // zero base capacity after layers are open: no reload
        setup(24'd0, 4'd1, 22'd17, 22'd29, 22'd1, 22'd50,
              {5'd3, 5'd2, 5'd6, 5'd0});
        random_items(300);
        setup(24'd7, 4'd3, 22'd200, 22'd3, 22'd8, 22'd90, 20'($urandom));
        random_items(250);

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
        $display("Sent %0d transactions over five register settings; %0d results checked,",
                 items_sent, sb.results_seen);
        $display("%0d hits, %0d adds with no layer left", sb.hits_seen, sb.exhausted_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
